[rtl/core/hdf_pkg.sv]
// Shared types and constants for the hash-based duplicate message filter.
`default_nettype none

package hdf_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int PTR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int HASH_W      = 32;
   localparam int BYTE_W      = 8;

   // request kinds
   localparam logic REQ_BYTE  = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   // one-at-a-time shift amounts
   localparam int MIX_SHL = 10;
   localparam int MIX_SHR = 6;
   localparam int FIN_SHL_A = 3;
   localparam int FIN_SHR   = 11;
   localparam int FIN_SHL_B = 15;

   typedef struct packed {
      logic              req_type;
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash_value;
      logic              is_new;
   } rsp_item_type;

   typedef struct packed {
      logic load;     // fold accepted byte into running hash (add step)
      logic mix;      // shift-add / shift-xor of the mix
      logic fin1;     // first finalize step, running hash back to zero
      logic fin2;     // second and third finalize steps
      logic compare;  // register per-entry match bits
      logic commit;   // reduce matches, insert, load output register
      logic clear;    // empty the table and zero the pointer
   } cmd_type;

   typedef struct packed {
      logic out_free;  // output register can take a result this cycle
   } status_type;

endpackage

`default_nettype wire

[rtl/core/hdf_ctrl.sv]
// Controller state machine: sequences the hash, finalize, compare and commit steps.
`default_nettype none

module hdf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire hdf_pkg::req_item_type req_data,
   input  wire hdf_pkg::status_type   sts,
   output hdf_pkg::cmd_type           cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MIX  = 3'd1;
   localparam logic [2:0] S_FIN1 = 3'd2;
   localparam logic [2:0] S_FIN2 = 3'd3;
   localparam logic [2:0] S_CMP  = 3'd4;
   localparam logic [2:0] S_RES  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       last_ff, last_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      last_in  = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.req_type == hdf_pkg::REQ_CLEAR) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  last_in  = req_data.last_byte;
                  state_in = S_MIX;
               end
            end
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            state_in = last_ff ? S_FIN1 : S_IDLE;
         end
         S_FIN1: begin
            cmd.fin1 = 1'b1;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            cmd.fin2 = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_RES;
         end
         S_RES: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/hdf_datapath.sv]
// Datapath: running hash, finalize steps, seen table with match bits, output register.
`default_nettype none

module hdf_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hdf_pkg::cmd_type      cmd,
   input  wire hdf_pkg::req_item_type req_data,
   output hdf_pkg::status_type        sts,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output hdf_pkg::rsp_item_type      rsp_data
);

   localparam int DEPTH = hdf_pkg::TABLE_DEPTH;
   localparam int PW    = hdf_pkg::PTR_W;
   localparam int HW    = hdf_pkg::HASH_W;

   logic [HW-1:0]    hash_ff, hash_in;
   logic [HW-1:0]    work_ff, work_in;
   logic [HW-1:0]    tbl_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [DEPTH-1:0] match_ff, match_in;
   logic [PW-1:0]    ptr_ff, ptr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   hdf_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [HW-1:0] mix_t;
   logic [HW-1:0] fin_t;
   logic          found;
   logic          do_insert;

   assign mix_t     = work_ff + (work_ff << hdf_pkg::MIX_SHL);
   assign fin_t     = work_ff ^ (work_ff >> hdf_pkg::FIN_SHR);
   assign found     = |match_ff;
   assign do_insert = cmd.commit && !found;

   // empty slots read as zero
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = valid_ff[i] ? (tbl_ff[i] == work_ff) : (work_ff == '0);
      end
   end

   always_comb begin
      hash_in = hash_ff;
      work_in = work_ff;
      if (cmd.load) begin
         work_in = hash_ff + HW'(req_data.data_byte);
      end
      if (cmd.mix) begin
         hash_in = mix_t ^ (mix_t >> hdf_pkg::MIX_SHR);
      end
      if (cmd.fin1) begin
         work_in = hash_ff + (hash_ff << hdf_pkg::FIN_SHL_A);
         hash_in = '0;
      end
      if (cmd.fin2) begin
         work_in = fin_t + (fin_t << hdf_pkg::FIN_SHL_B);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      ptr_in   = ptr_ff;
      if (cmd.clear) begin
         valid_in = '0;
         ptr_in   = '0;
      end else if (do_insert) begin
         valid_in[ptr_ff] = 1'b1;
         ptr_in = (ptr_ff == PW'(DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_in.hash_value = work_ff;
         rsp_in.is_new     = !found;
         rsp_valid_in      = 1'b1;
      end
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= '0;
         valid_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rsp_ff  <= rsp_in;
      if (cmd.compare) begin
         match_ff <= match_in;
      end
      if (do_insert) begin
         tbl_ff[ptr_ff] <= work_ff;
      end
   end

endmodule

`default_nettype wire

[rtl/core/hash_dedup_filter.sv]
// Top level of the duplicate message filter built on a one-at-a-time hash.
//
// Message bytes come in one per req transfer and are folded into a running
// 32-bit one-at-a-time hash. On the byte flagged last_byte the hash is
// finalized and checked against a table of TABLE_DEPTH earlier hashes; one
// rsp transfer carries the hash and is_new, and a new hash is stored at a
// wrapping insert pointer (oldest entry overwritten once the table is full).
// Empty slots hold zero, so a zero hash reads as already seen while any slot
// is still empty; once every slot holds a hash, a zero hash misses, is stored
// and is reported new like any other. A clear request (req_type = 1) empties
// the table and zeroes the pointer without disturbing a message in progress;
// it gives no rsp transfer. A non-final byte is worked as an add, then the
// shift-add/xor mix; a final byte goes on through two finalize steps, a
// registered parallel compare and commit, and the commit waits for the
// output register while rsp_stall holds it. The output register lets the
// next request be taken while a result is still pending. Reset is
// synchronous and clears the table through per-entry valid bits.
`default_nettype none

module hash_dedup_filter (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire hdf_pkg::req_item_type req_data,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output hdf_pkg::rsp_item_type      rsp_data
);

   hdf_pkg::cmd_type    cmd;
   hdf_pkg::status_type sts;

   // sequencer: one item at a time, stall held high while it is worked on
   hdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hash arithmetic, seen table, output register
   hdf_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // at most one datapath step per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mix, cmd.fin1, cmd.fin2, cmd.compare, cmd.commit, cmd.clear}))
      else $error("more than one datapath command");

   // commit only into a free output register, and it shows up next cycle
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("commit while output register is held");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result not presented");

   // a stalled result stays put until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

`default_nettype wire

[test/hash_dedup_filter_tb.sv]
// Self-checking testbench for the one-at-a-time hash duplicate message filter.
`timescale 1ns / 100ps

module hash_dedup_filter_tb;
   import hdf_pkg::*;

   // Hash predictor plus the queue of results still owed by the block.
   class dedup_scoreboard;
      logic [HASH_W-1:0] run_hash;
      logic [HASH_W-1:0] seen [TABLE_DEPTH];
      int unsigned       ins_ptr;
      rsp_item_type      owed_q[$];
      int                errors;
      int                n_msgs, n_dups, n_zero, n_clears, n_wraps;

      function new();
         run_hash = '0;
         foreach (seen[i]) seen[i] = '0;
         ins_ptr  = 0;
         errors   = 0;
         n_msgs   = 0;
         n_dups   = 0;
         n_zero   = 0;
         n_clears = 0;
         n_wraps  = 0;
      endfunction

      function logic [HASH_W-1:0] fold_byte(logic [HASH_W-1:0] h, logic [BYTE_W-1:0] b);
         logic [HASH_W-1:0] t;
         t = h + HASH_W'(b);
         t = t + (t << MIX_SHL);
         t = t ^ (t >> MIX_SHR);
         return t;
      endfunction

      function logic [HASH_W-1:0] finish_hash(logic [HASH_W-1:0] h);
         logic [HASH_W-1:0] t;
         t = h + (h << FIN_SHL_A);
         t = t ^ (t >> FIN_SHR);
         t = t + (t << FIN_SHL_B);
         return t;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // Called once per accepted request transfer.
      function void note_request(req_item_type r);
         rsp_item_type      owed;
         logic [HASH_W-1:0] h;
         bit                hit;
         if (r.req_type == REQ_CLEAR) begin
            // table and pointer only; a message in progress keeps its hash
            foreach (seen[i]) seen[i] = '0;
            ins_ptr = 0;
            n_clears++;
            return;
         end
         run_hash = fold_byte(run_hash, r.data_byte);
         if (!r.last_byte)
            return;
         h        = finish_hash(run_hash);
         run_hash = '0;
         hit      = 1'b0;
         // empty slots hold zero, so a zero hash hits while any slot is still empty
         foreach (seen[i])
            if (seen[i] == h)
               hit = 1'b1;
         if (!hit) begin
            seen[ins_ptr] = h;
            if (ins_ptr == TABLE_DEPTH - 1) begin
               ins_ptr = 0;
               n_wraps++;
            end else begin
               ins_ptr++;
            end
         end else begin
            n_dups++;
         end
         if (h == '0)
            n_zero++;
         n_msgs++;
         owed.hash_value = h;
         owed.is_new     = !hit;
         owed_q.push_back(owed);
      endfunction

      // Called once per accepted result transfer.
      function void check_result(rsp_item_type r);
         rsp_item_type owed;
         if (owed_q.size() == 0) begin
            $error("unexpected result: hash_value %h is_new %0b", r.hash_value, r.is_new);
            errors++;
            return;
         end
         owed = owed_q.pop_front();
         if (r.hash_value !== owed.hash_value) begin
            $error("hash_value: expected %h, got %h", owed.hash_value, r.hash_value);
            errors++;
         end
         if (r.is_new !== owed.is_new) begin
            $error("is_new: expected %0b, got %0b", owed.is_new, r.is_new);
            errors++;
         end
      endfunction
   endclass

   localparam int MAX_LEN  = 24;
   localparam int HIST_N   = 64;
   localparam int N_PHASES = 5;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;

   dedup_scoreboard dedup_sb;

   int send_idle_pct;
   int rsp_stall_pct;
   int n_sent;

   // recent messages, replayed to provoke duplicates and post-wrap misses
   logic [BYTE_W-1:0] hist_bytes [HIST_N][MAX_LEN];
   int                hist_len [HIST_N];
   int                hist_wr;
   int                hist_cnt;
   logic [BYTE_W-1:0] msg_bytes [MAX_LEN];

   hash_dedup_filter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver back-pressure, changed only on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= (rsp_stall_pct > 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   // Result monitor: a transfer completes on a rising edge with valid high and stall low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         dedup_sb.check_result(rsp_data);
   end

   function automatic req_item_type mk_req(logic kind, logic [BYTE_W-1:0] b, logic last);
      req_item_type r;
      r.req_type  = kind;
      r.data_byte = b;
      r.last_byte = last;
      return r;
   endfunction

   // Entered and left at a falling edge. Valid stays high into the next
   // transfer unless an idle gap is drawn.
   task automatic send_req(input req_item_type item);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (req_stall);
      dedup_sb.note_request(item);
      n_sent++;
      @(negedge clock);
   endtask

   // Sender holds off until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (dedup_sb.pending() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Send msg_bytes[0..len-1] as one message; rarely a clear is slipped in
   // before a byte, which must not disturb the running hash.
   task automatic send_message(input int len);
      for (int j = 0; j < len; j++) begin
         if ($urandom_range(199) == 0)
            send_req(mk_req(REQ_CLEAR, BYTE_W'($urandom_range(255)), 1'($urandom_range(1))));
         send_req(mk_req(REQ_BYTE, msg_bytes[j], j == len - 1));
      end
   endtask

   // Watchdog.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int phase_end [N_PHASES];
      int idle_tab  [N_PHASES];
      int stall_tab [N_PHASES];
      int len;
      int idx;
      int waited;

      dedup_sb      = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      n_sent        = 0;
      hist_wr       = 0;
      hist_cnt      = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part ---
      // single zero byte: zero hash, reported as already seen
      send_req(mk_req(REQ_BYTE, 8'h00, 1'b1));
      // all-ones byte: new, then the same message again is a duplicate
      send_req(mk_req(REQ_BYTE, 8'hFF, 1'b1));
      send_req(mk_req(REQ_BYTE, 8'hFF, 1'b1));
      // two zero bytes still hash to zero
      send_req(mk_req(REQ_BYTE, 8'h00, 1'b0));
      send_req(mk_req(REQ_BYTE, 8'h00, 1'b1));
      // multi-byte message with mixed bit patterns
      send_req(mk_req(REQ_BYTE, 8'h5A, 1'b0));
      send_req(mk_req(REQ_BYTE, 8'hA5, 1'b0));
      send_req(mk_req(REQ_BYTE, 8'hFF, 1'b1));
      // clear in the middle of a message; the message carries on
      send_req(mk_req(REQ_BYTE, 8'h12, 1'b0));
      send_req(mk_req(REQ_CLEAR, 8'hFF, 1'b1));
      send_req(mk_req(REQ_BYTE, 8'h34, 1'b1));
      // after the clear the all-ones message is new again
      send_req(mk_req(REQ_BYTE, 8'hFF, 1'b1));
      // clear with the other field values
      send_req(mk_req(REQ_CLEAR, 8'h00, 1'b0));
      send_req(mk_req(REQ_BYTE, 8'hFF, 1'b1));
      send_req(mk_req(REQ_BYTE, 8'h80, 1'b0));
      send_req(mk_req(REQ_BYTE, 8'h01, 1'b1));
      send_req(mk_req(REQ_BYTE, 8'h5A, 1'b0));
      send_req(mk_req(REQ_BYTE, 8'hA5, 1'b0));
      send_req(mk_req(REQ_BYTE, 8'hFF, 1'b1));
      drain_results();

      // --- random part, one idling profile per phase ---
      phase_end = '{n_sent + 230, n_sent + 440, n_sent + 650, n_sent + 860, n_sent + 1050};
      idle_tab  = '{0, 52, 0, 38, 0};
      stall_tab = '{0, 0, 52, 38, 0};

      for (int ph = 0; ph < N_PHASES; ph++) begin
         send_idle_pct = idle_tab[ph];
         rsp_stall_pct = stall_tab[ph];
         while (n_sent < phase_end[ph]) begin
            if ($urandom_range(99) < 2) begin
               // rare clears, so the table usually fills and wraps in between
               send_req(mk_req(REQ_CLEAR, BYTE_W'($urandom_range(255)), 1'($urandom_range(1))));
            end else if (hist_cnt > 0 && $urandom_range(99) < 35) begin
               // replay a recent message: a hit, or a miss if it was overwritten
               idx = $urandom_range(hist_cnt - 1);
               len = hist_len[idx];
               for (int j = 0; j < len; j++)
                  msg_bytes[j] = hist_bytes[idx][j];
               send_message(len);
            end else begin
               len = ($urandom_range(99) < 90) ? $urandom_range(1, 6)
                                               : $urandom_range(7, MAX_LEN);
               if ($urandom_range(99) < 3) begin
                  for (int j = 0; j < len; j++)
                     msg_bytes[j] = '0;
               end else begin
                  for (int j = 0; j < len; j++)
                     msg_bytes[j] = BYTE_W'($urandom_range(255));
               end
               for (int j = 0; j < len; j++)
                  hist_bytes[hist_wr][j] = msg_bytes[j];
               hist_len[hist_wr] = len;
               hist_wr = (hist_wr + 1) % HIST_N;
               if (hist_cnt < HIST_N)
                  hist_cnt++;
               send_message(len);
            end
         end
         drain_results();
      end

      // --- wind-down ---
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      req_valid <= 1'b0;
      waited = 0;
      while (dedup_sb.pending() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (dedup_sb.pending() != 0) begin
         $error("%0d expected results never arrived", dedup_sb.pending());
         dedup_sb.errors++;
      end

      $display("Run covered %0d request transfers, %0d messages, %0d clears.",
               n_sent, dedup_sb.n_msgs, dedup_sb.n_clears);
      $display("Duplicates %0d (zero-hash %0d), table wraps %0d, errors %0d.",
               dedup_sb.n_dups, dedup_sb.n_zero, dedup_sb.n_wraps, dedup_sb.errors);
      if (dedup_sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[hash_dedup_filter.f]
rtl/core/hdf_pkg.sv
rtl/core/hdf_ctrl.sv
rtl/core/hdf_datapath.sv
rtl/core/hash_dedup_filter.sv
test/hash_dedup_filter_tb.sv
